// ===== hdl/hts_pkg.sv =====
//==============================================================================
// hts_pkg
// Shared types, constants and arithmetic helpers of the Holt smoothing block.
//==============================================================================
`default_nettype none

package hts_pkg;

    localparam int MaxHorizon = 32;
    localparam int HorizonW   = 6;
    localparam int GainW      = 16;
    localparam int SampleW    = 32;
    localparam int ValueW     = 48;
    localparam int CountW     = 32;
    localparam int SumW       = 64;
    localparam int MulAW      = 49;
    localparam int MulBW      = 18;
    localparam int ProdW      = 67;
    localparam int AccW       = 68;
    localparam int FcW        = 56;
    localparam int SqW        = 66;
    localparam int AddrW      = 4;
    localparam int DataW      = 32;

    localparam logic signed [AccW-1:0] AccMax    = {{(AccW-47){1'b0}}, {47{1'b1}}};
    localparam logic signed [AccW-1:0] AccMin    = {{(AccW-47){1'b1}}, {47{1'b0}}};
    localparam logic signed [AccW-1:0] RoundHalf = AccW'(32768);
    localparam logic [ValueW-1:0]      ValueMax  = {1'b0, {(ValueW-1){1'b1}}};

    typedef enum logic [1:0] {
        KIND_FIT = 2'd0,
        KIND_FC  = 2'd1,
        KIND_MSE = 2'd2,
        KIND_INV = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        POS_FIRST  = 2'd0,
        POS_SECOND = 2'd1,
        POS_LATER  = 2'd2
    } t_pos;

    typedef enum logic [1:0] {
        REG_LEVEL_GAIN = 2'd0,
        REG_TREND_GAIN = 2'd1,
        REG_HORIZON    = 2'd2
    } t_reg;

    typedef enum logic [4:0] {
        S_IDLE, S_L1, S_L2, S_LN, S_T1, S_T2, S_TN, S_FIT, S_ERR,
        S_SQ1, S_SQ2, S_SQ3, S_SQA, S_ACC, S_EMIT_FIT,
        S_FC_ADD, S_FC_EMIT, S_DIV, S_EMIT_MSE, S_EMIT_INV
    } t_state;

    typedef struct packed {
        logic signed [SampleW-1:0] sample;
        logic                      last;
        t_pos                      pos;
    } t_item;

    typedef struct packed {
        logic [GainW-1:0]    level_gain;
        logic [GainW-1:0]    trend_gain;
        logic [HorizonW-1:0] horizon;
    } t_cfg;

    function automatic logic signed [ValueW-1:0] sat48(input logic signed [AccW-1:0] v);
        logic signed [ValueW-1:0] r;
        if (v > AccMax) begin
            r = AccMax[ValueW-1:0];
        end else if (v < AccMin) begin
            r = AccMin[ValueW-1:0];
        end else begin
            r = v[ValueW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [ValueW-1:0] blend_norm(input logic signed [AccW-1:0] s);
        logic signed [AccW-1:0] t;
        t = s + RoundHalf;
        t = t >>> 16;
        return sat48(t);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/hts_front.sv =====
//==============================================================================
// hts_front
// Accepts samples, tags each with its place in the series, queues two deep.
//==============================================================================
`default_nettype none

module hts_front
    import hts_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic signed [SampleW-1:0] i_sample,
    input  wire logic                      i_last_sample,
    output logic                           o_q_valid,
    output t_item                          o_item,
    input  wire logic                      i_pop
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_pos       r_pos;
    logic       push;
    logic       pop;
    t_item      w_item;

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_item    = r_mem[r_rp];
    assign push      = i_valid && o_ready;
    assign pop       = i_pop && o_q_valid;

    always_comb begin
        w_item.sample = i_sample;
        w_item.last   = i_last_sample;
        w_item.pos    = r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
            r_pos <= POS_FIRST;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
                if (i_last_sample) begin
                    r_pos <= POS_FIRST;
                end else if (r_pos == POS_FIRST) begin
                    r_pos <= POS_SECOND;
                end else begin
                    r_pos <= POS_LATER;
                end
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/hts_back.sv =====
//==============================================================================
// hts_back
// Sequencer over one shared multiplier: level and trend update, squared error,
// forecasts, and a bit-serial divider for the mean squared error.
//==============================================================================
`default_nettype none

module hts_back
    import hts_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cfg                     i_cfg,
    input  wire logic                     i_q_valid,
    input  wire t_item                    i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output t_kind                         o_kind,
    output logic signed [ValueW-1:0]      o_value,
    output logic                          o_last_result
);

    t_state                   r_state, n_state;
    logic signed [ValueW-1:0] r_level, n_level;
    logic signed [ValueW-1:0] r_trend, n_trend;
    logic [CountW-1:0]        r_count, n_count;
    logic [SumW-1:0]          r_sum, n_sum;
    logic                     r_o_valid, n_o_valid;

    logic signed [ValueW-1:0] r_x, n_x;
    logic                     r_last, n_last;
    logic signed [ValueW-1:0] r_old, n_old;
    logic signed [ValueW-1:0] r_y, n_y;
    logic signed [ValueW-1:0] r_fit, n_fit;
    logic [ValueW-1:0]        r_abs, n_abs;
    logic signed [AccW-1:0]   r_acc, n_acc;
    logic [SqW-1:0]           r_sq, n_sq;
    logic signed [FcW-1:0]    r_fc, n_fc;
    logic [HorizonW-1:0]      r_i, n_i;
    logic [SumW-1:0]          r_quo, n_quo;
    logic [CountW-1:0]        r_rem, n_rem;
    logic [CountW-1:0]        r_div, n_div;
    logic [5:0]               r_step, n_step;
    t_kind                    r_o_kind, n_o_kind;
    logic signed [ValueW-1:0] r_o_value, n_o_value;
    logic                     r_o_last, n_o_last;

    logic signed [MulAW-1:0]  mul_a;
    logic signed [MulBW-1:0]  mul_b;
    logic signed [ProdW-1:0]  r_prod;

    logic                     out_free;
    logic signed [ValueW-1:0] x_in;
    logic signed [ValueW-1:0] err;
    logic signed [MulAW-1:0]  err49;
    logic [SumW-1:0]          sq;
    logic [SumW:0]            sum_ext;
    logic [CountW:0]          trial;
    logic                     ge;

    assign o_valid       = r_o_valid;
    assign o_kind        = r_o_kind;
    assign o_value       = r_o_value;
    assign o_last_result = r_o_last;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_comb begin
        n_state   = r_state;
        n_level   = r_level;
        n_trend   = r_trend;
        n_count   = r_count;
        n_sum     = r_sum;
        n_o_valid = r_o_valid && !i_ready;
        n_x       = r_x;
        n_last    = r_last;
        n_old     = r_old;
        n_y       = r_y;
        n_fit     = r_fit;
        n_abs     = r_abs;
        n_acc     = r_acc;
        n_sq      = r_sq;
        n_fc      = r_fc;
        n_i       = r_i;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_div     = r_div;
        n_step    = r_step;
        n_o_kind  = r_o_kind;
        n_o_value = r_o_value;
        n_o_last  = r_o_last;
        mul_a     = '0;
        mul_b     = '0;
        o_pop     = 1'b0;
        out_free  = !r_o_valid || i_ready;
        x_in      = ValueW'(i_item.sample);
        err       = sat48(AccW'(r_x) - AccW'(r_fit));
        err49     = MulAW'(err);
        sq        = (r_abs[ValueW-1:40] != '0 || r_sq[SqW-1:SumW] != '0) ? '1 : r_sq[SumW-1:0];
        sum_ext   = {1'b0, r_sum} + {1'b0, sq};
        trial     = {r_rem, r_quo[SumW-1]};
        ge        = (trial >= {1'b0, r_div});

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop  = 1'b1;
                    n_x    = x_in;
                    n_last = i_item.last;
                    n_old  = r_level;
                    n_count = (r_count == '1) ? r_count : r_count + 1'b1;
                    unique case (i_item.pos)
                        POS_FIRST: begin
                            n_level = x_in;
                            n_count = CountW'(1);
                            if (i_item.last) begin
                                n_state = S_EMIT_INV;
                            end
                        end
                        POS_SECOND: begin
                            n_trend = sat48(AccW'(x_in) - AccW'(r_level));
                            n_state = S_L1;
                        end
                        default: begin
                            n_state = S_L1;
                        end
                    endcase
                end
            end
            S_L1: begin
                mul_a   = MulAW'(r_x);
                mul_b   = MulBW'({2'b00, i_cfg.level_gain});
                n_y     = sat48(AccW'(r_level) + AccW'(r_trend));
                n_state = S_L2;
            end
            S_L2: begin
                mul_a   = MulAW'(r_y);
                mul_b   = MulBW'(18'd65536 - {2'b00, i_cfg.level_gain});
                n_acc   = AccW'(r_prod);
                n_state = S_LN;
            end
            S_LN: begin
                n_level = blend_norm(r_acc + AccW'(r_prod));
                n_state = S_T1;
            end
            S_T1: begin
                mul_a   = MulAW'(sat48(AccW'(r_level) - AccW'(r_old)));
                mul_b   = MulBW'({2'b00, i_cfg.trend_gain});
                n_state = S_T2;
            end
            S_T2: begin
                mul_a   = MulAW'(r_trend);
                mul_b   = MulBW'(18'd65536 - {2'b00, i_cfg.trend_gain});
                n_acc   = AccW'(r_prod);
                n_state = S_TN;
            end
            S_TN: begin
                n_trend = blend_norm(r_acc + AccW'(r_prod));
                n_state = S_FIT;
            end
            S_FIT: begin
                n_fit   = sat48(AccW'(r_level) + AccW'(r_trend));
                n_state = S_ERR;
            end
            S_ERR: begin
                n_abs   = (err49 < 0) ? ValueW'(-err49) : ValueW'(err49);
                n_state = S_SQ1;
            end
            S_SQ1: begin
                mul_a   = MulAW'({1'b0, r_abs});
                mul_b   = MulBW'({2'b00, r_abs[15:0]});
                n_state = S_SQ2;
            end
            S_SQ2: begin
                mul_a   = MulAW'({1'b0, r_abs});
                mul_b   = MulBW'({2'b00, r_abs[31:16]});
                n_sq    = {15'b0, r_prod[ProdW-1:16]};
                n_state = S_SQ3;
            end
            S_SQ3: begin
                mul_a   = MulAW'({1'b0, r_abs});
                mul_b   = MulBW'({10'b0, r_abs[39:32]});
                n_sq    = r_sq + r_prod[SqW-1:0];
                n_state = S_SQA;
            end
            S_SQA: begin
                n_sq    = r_sq + {r_prod[49:0], 16'b0};
                n_state = S_ACC;
            end
            S_ACC: begin
                n_sum   = sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
                n_state = S_EMIT_FIT;
            end
            S_EMIT_FIT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = KIND_FIT;
                    n_o_value = r_fit;
                    n_o_last  = !r_last;
                    n_fc      = FcW'(r_level);
                    n_i       = '0;
                    n_state   = r_last ? S_FC_ADD : S_IDLE;
                end
            end
            S_FC_ADD: begin
                if (r_i == i_cfg.horizon) begin
                    n_quo   = r_sum;
                    n_rem   = '0;
                    n_div   = r_count - 1'b1;
                    n_step  = '0;
                    n_state = S_DIV;
                end else begin
                    n_fc    = r_fc + FcW'(r_trend);
                    n_i     = r_i + 1'b1;
                    n_state = S_FC_EMIT;
                end
            end
            S_FC_EMIT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = KIND_FC;
                    n_o_value = sat48(AccW'(r_fc));
                    n_o_last  = 1'b0;
                    n_state   = S_FC_ADD;
                end
            end
            S_DIV: begin
                n_rem  = ge ? CountW'(trial - {1'b0, r_div}) : trial[CountW-1:0];
                n_quo  = {r_quo[SumW-2:0], ge};
                n_step = r_step + 1'b1;
                if (r_step == '1) begin
                    n_state = S_EMIT_MSE;
                end
            end
            S_EMIT_MSE: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = KIND_MSE;
                    n_o_value = (r_quo[SumW-1:ValueW-1] != '0) ? ValueMax : r_quo[ValueW-1:0];
                    n_o_last  = 1'b1;
                    n_level   = '0;
                    n_trend   = '0;
                    n_count   = '0;
                    n_sum     = '0;
                    n_state   = S_IDLE;
                end
            end
            S_EMIT_INV: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = KIND_INV;
                    n_o_value = '0;
                    n_o_last  = 1'b1;
                    n_level   = '0;
                    n_trend   = '0;
                    n_count   = '0;
                    n_sum     = '0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_level   <= '0;
            r_trend   <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_level   <= n_level;
            r_trend   <= n_trend;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x       <= n_x;
        r_last    <= n_last;
        r_old     <= n_old;
        r_y       <= n_y;
        r_fit     <= n_fit;
        r_abs     <= n_abs;
        r_acc     <= n_acc;
        r_sq      <= n_sq;
        r_fc      <= n_fc;
        r_i       <= n_i;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_div     <= n_div;
        r_step    <= n_step;
        r_o_kind  <= n_o_kind;
        r_o_value <= n_o_value;
        r_o_last  <= n_o_last;
    end

endmodule

`default_nettype wire

// ===== hdl/holt_trend_smoothing_forecast.sv =====
// Holt double exponential smoothing of a Q16.16 sample stream. A first sample
// only sets the level. Every later sample makes, in the back end, seven
// passes through the one shared 49x18 multiplier for the level blend, trend
// blend and squared error, with normalization and saturation steps between.
// A last sample then adds the forecasts (horizon, capped at 32) and the
// bit-serial mean squared error divide and its result. A two-item queue lets
// samples arrive while the back end works, and an output register lets the
// back end run on while a result waits to be taken.
//==============================================================================
// holt_trend_smoothing_forecast
// Top level: APB register file, front queue and back-end sequencer.
//==============================================================================
`default_nettype none

module holt_trend_smoothing_forecast
    import hts_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [AddrW-1:0]          paddr,
    input  wire logic [DataW-1:0]          pwdata,
    output logic [DataW-1:0]               prdata,
    output logic                           pready,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic signed [SampleW-1:0] i_sample,
    input  wire logic                      i_last_sample,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [1:0]                     o_kind,
    output logic signed [ValueW-1:0]       o_value,
    output logic                           o_last_result
);

    logic [GainW-1:0]    r_level_gain;
    logic [GainW-1:0]    r_trend_gain;
    logic [HorizonW-1:0] r_horizon;
    logic                wr_en;
    t_reg                reg_sel;
    t_cfg                cfg;
    logic                q_valid;
    t_item               q_item;
    logic                q_pop;
    t_kind               kind;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = t_reg'(paddr[3:2]);
    assign o_kind  = kind;

    always_comb begin
        cfg.level_gain = r_level_gain;
        cfg.trend_gain = r_trend_gain;
        cfg.horizon    = (r_horizon > HorizonW'(MaxHorizon)) ? HorizonW'(MaxHorizon)
                                                             : r_horizon;
    end

    always_comb begin
        unique case (reg_sel)
            REG_LEVEL_GAIN: prdata = DataW'(r_level_gain);
            REG_TREND_GAIN: prdata = DataW'(r_trend_gain);
            REG_HORIZON:    prdata = DataW'(r_horizon);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_gain <= GainW'(32768);
            r_trend_gain <= GainW'(32768);
            r_horizon    <= HorizonW'(1);
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_LEVEL_GAIN: r_level_gain <= pwdata[GainW-1:0];
                REG_TREND_GAIN: r_trend_gain <= pwdata[GainW-1:0];
                REG_HORIZON:    r_horizon    <= pwdata[HorizonW-1:0];
                default:        r_horizon    <= r_horizon;
            endcase
        end
    end

    hts_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .i_last_sample (i_last_sample),
        .o_q_valid     (q_valid),
        .o_item        (q_item),
        .i_pop         (q_pop)
    );

    hts_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_q_valid     (q_valid),
        .i_item        (q_item),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (kind),
        .o_value       (o_value),
        .o_last_result (o_last_result)
    );

endmodule

`default_nettype wire

// ===== hdl/hts_check.sv =====
//==============================================================================
// hts_check
// Port-level checks of the Holt smoothing block, bound to the top level.
//==============================================================================
`default_nettype none

module hts_check
    import hts_pkg::*;
(
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      pready,
    input wire logic                      o_valid,
    input wire logic                      i_ready,
    input wire logic [1:0]                o_kind,
    input wire logic signed [ValueW-1:0]  o_value,
    input wire logic                      o_last_result
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value) && $stable(o_kind)
                                && $stable(o_last_result))
        else $error("result changed while stalled");

    a_inv_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_INV |-> o_last_result && o_value == '0)
        else $error("invalid result not final or nonzero");

    a_mse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_MSE |-> o_last_result && !o_value[ValueW-1])
        else $error("mean squared error not final or negative");

    a_fc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_FC |-> !o_last_result)
        else $error("forecast marked final");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind holt_trend_smoothing_forecast hts_check u_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .pready        (pready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_kind        (o_kind),
    .o_value       (o_value),
    .o_last_result (o_last_result)
);

`default_nettype wire
